// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion violated");

`endif

// ----- rtl/emv_pkg.sv -----
// Types and constants for the multi-turn encoder velocity block.
package emv_pkg;

	localparam int TOTAL_W    = 44;
	localparam int VEL_W      = 36;
	localparam int TURN_W     = 32;
	localparam int JUMP_W     = 12;
	localparam int HZ_W       = 24;
	localparam int MINT_W     = 24;
	localparam int KEEP_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_DATA_W = 80;

	localparam logic [KEEP_W-1:0] KEEP_ONE = 9'd256;

	localparam logic [VEL_W-1:0] VEL_POS_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_NEG_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	localparam logic [JUMP_W-1:0] JUMP_RESET = 12'd3276;
	localparam logic [HZ_W-1:0]   HZ_RESET   = 24'd9000000;
	localparam logic [MINT_W-1:0] MINT_RESET = 24'd9;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 9'd205;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JUMP_LIMIT  = 2'd0,
		CFG_TICK_HZ     = 2'd1,
		CFG_MIN_TICKS   = 2'd2,
		CFG_FILTER_KEEP = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UNWRAP,
		ST_STEP,
		ST_MUL_V,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SAT,
		ST_MUL_OLD,
		ST_MUL_NEW,
		ST_FILT,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/emv_div.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module emv_div #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   sub;
	logic             ge;
	logic [DEN_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[NUM_W-1]};
		ge       = (shifted >= {1'b0, den_q});
		sub      = shifted - {1'b0, den_q};
		rem_next = ge ? sub[DEN_W-1:0] : shifted[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out of the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/encoder_multiturn_velocity.sv -----
// Top level: multi-turn encoder angle unwrapper with filtered velocity estimate.
// One item at a time: a new item is accepted only in the idle state, after the last
// result has loaded into the output register. The bit-serial divider produces one quotient
// bit per cycle over ANGLE_BITS + 26 bits.
// Reset (arst_n low, asynchronous): registers to reset values, turn/history/filter to zero.
module encoder_multiturn_velocity #(
	parameter int ANGLE_BITS = 12,
	parameter int STAMP_BITS = 24
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	// Input items
	input  logic                                                 s_tvalid,
	output logic                                                 s_tready,
	// raw_angle [ANGLE_BITS-1:0], tick_stamp next, zero fill to bytes
	input  logic [((ANGLE_BITS+STAMP_BITS+7)/8)*8-1:0]           s_tdata,
	// Result items
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	// total_angle [43:0], velocity [79:44]
	output logic [emv_pkg::OUT_DATA_W-1:0]                       m_tdata,
	// Configuration writes
	input  logic                                                 cfg_valid,
	output logic                                                 cfg_ready,
	input  logic [emv_pkg::CFG_IDX_W-1:0]                        cfg_index,
	input  logic [emv_pkg::CFG_DATA_W-1:0]                       cfg_data
);

`include "assert_macros.svh"

	localparam int TOTAL_W = emv_pkg::TOTAL_W;
	localparam int VEL_W   = emv_pkg::VEL_W;
	localparam int TURN_W  = emv_pkg::TURN_W;
	localparam int KEEP_W  = emv_pkg::KEEP_W;

	// Clamped step is within three turns.
	localparam int STEP_W  = ANGLE_BITS + 3;
	// |step * tick_hz| magnitude width.
	localparam int MAG_W   = ANGLE_BITS + 2 + emv_pkg::HZ_W;
	localparam int DEN_W   = (STAMP_BITS + 1 > emv_pkg::MINT_W) ? STAMP_BITS + 1
	                                                            : emv_pkg::MINT_W;
	localparam int JCMP_W  = (ANGLE_BITS > emv_pkg::JUMP_W) ? ANGLE_BITS : emv_pkg::JUMP_W;
	localparam int MUL_A_W = (VEL_W > STEP_W) ? VEL_W : STEP_W;
	localparam int MUL_B_W = emv_pkg::HZ_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = VEL_W + KEEP_W;
	localparam int CMPQ_W  = ((MAG_W > VEL_W) ? MAG_W : VEL_W) + 1;

	localparam logic signed [TOTAL_W-1:0] HALF_TURN =
		TOTAL_W'(64'd1 << (ANGLE_BITS - 1));
	localparam logic signed [TOTAL_W-1:0] FULL_TURN =
		TOTAL_W'(64'd1 << ANGLE_BITS);
	localparam logic signed [TOTAL_W-1:0] STEP_LIM =
		TOTAL_W'(64'd3 << ANGLE_BITS);

	// Configuration registers
	logic [emv_pkg::JUMP_W-1:0] jump_limit_q;
	logic [emv_pkg::HZ_W-1:0]   tick_hz_q;
	logic [emv_pkg::MINT_W-1:0] min_ticks_q;
	logic [KEEP_W-1:0]          filter_keep_q;

	// Sequencer and history
	emv_pkg::state_t state_q, state_next;
	logic [ANGLE_BITS-1:0]    prev_raw_q;
	logic [TURN_W-1:0]        turn_count_q;
	logic [TOTAL_W-1:0]       prev_total_q;
	logic [STAMP_BITS-1:0]    prev_stamp_q;
	logic signed [VEL_W-1:0]  filt_q;
	logic                     out_valid_q;

	// Working registers of one item
	logic [ANGLE_BITS-1:0]    raw_q;
	logic [STAMP_BITS-1:0]    stamp_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [DEN_W-1:0]         den_q;
	logic signed [STEP_W-1:0] step_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [VEL_W-1:0]  vel_q;
	logic [emv_pkg::OUT_DATA_W-1:0] out_data_q;

	// Sequencer outputs
	logic in_take;
	logic div_start;
	logic out_free;
	logic out_load;

	// Unwrap path
	logic signed [ANGLE_BITS:0]          d_s;
	logic [ANGLE_BITS:0]                 ad_full;
	logic                                jump_hit;
	logic [TURN_W-1:0]                   turn_next;
	logic [TURN_W+ANGLE_BITS-1:0]        turn_sh;
	logic [TOTAL_W-1:0]                  total_next;
	logic                                stamp_lt;
	logic [STAMP_BITS:0]                 ticks;
	logic [DEN_W-1:0]                    ticks_e;
	logic [DEN_W-1:0]                    floor_t;
	logic [DEN_W-1:0]                    den_next;

	// Step path
	logic signed [TOTAL_W-1:0] diff_s;
	logic signed [TOTAL_W-1:0] wrap_s;
	logic signed [TOTAL_W-1:0] clamp_s;

	// Shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [KEEP_W-1:0]         keep_sat;
	logic [KEEP_W-1:0]         keep_inv;

	// Divide and saturate
	logic [PROD_W-1:0]  mag_full;
	logic [MAG_W-1:0]   div_num;
	logic               div_done;
	logic [MAG_W-1:0]   div_quo;
	logic [CMPQ_W-1:0]  q_e;
	logic [CMPQ_W-1:0]  q_neg;
	logic [CMPQ_W-1:0]  pos_lim;
	logic [CMPQ_W-1:0]  neg_lim;
	logic signed [VEL_W-1:0] vel_next;

	// Filter
	logic signed [SUM_W-1:0] sum_s;
	logic signed [SUM_W-1:0] sum_sh;

	// Configuration port: always ready; the user must write only while the block is idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q  <= emv_pkg::JUMP_RESET;
			tick_hz_q     <= emv_pkg::HZ_RESET;
			min_ticks_q   <= emv_pkg::MINT_RESET;
			filter_keep_q <= emv_pkg::KEEP_RESET;
		end else if (cfg_valid) begin
			case (emv_pkg::cfg_reg_t'(cfg_index))
				emv_pkg::CFG_JUMP_LIMIT: begin
					jump_limit_q <= cfg_data[emv_pkg::JUMP_W-1:0];
				end
				emv_pkg::CFG_TICK_HZ: begin
					tick_hz_q <= cfg_data[emv_pkg::HZ_W-1:0];
				end
				emv_pkg::CFG_MIN_TICKS: begin
					min_ticks_q <= cfg_data[emv_pkg::MINT_W-1:0];
				end
				emv_pkg::CFG_FILTER_KEEP: begin
					filter_keep_q <= cfg_data[KEEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Turn counting: a raw step beyond the jump limit moves the count against its sign.
	always_comb begin
		d_s       = signed'({1'b0, raw_q}) - signed'({1'b0, prev_raw_q});
		ad_full   = d_s[ANGLE_BITS] ? unsigned'(-d_s) : unsigned'(d_s);
		jump_hit  = (JCMP_W'(ad_full[ANGLE_BITS-1:0]) > JCMP_W'(jump_limit_q));
		if (!jump_hit) begin
			turn_next = turn_count_q;
		end else if (d_s[ANGLE_BITS]) begin
			turn_next = turn_count_q + TURN_W'(1);
		end else begin
			turn_next = turn_count_q - TURN_W'(1);
		end
		turn_sh    = {turn_next, {ANGLE_BITS{1'b0}}};
		total_next = TOTAL_W'(turn_sh) + TOTAL_W'(raw_q);
	end

	// Elapsed ticks of the down-counter, with wrap, floored at min_ticks (zero acts as one).
	always_comb begin
		stamp_lt = (stamp_q < prev_stamp_q);
		if (stamp_lt) begin
			ticks = {1'b0, prev_stamp_q - stamp_q};
		end else begin
			ticks = {1'b0, ~stamp_q} + {1'b0, prev_stamp_q};
		end
		ticks_e  = DEN_W'(ticks);
		floor_t  = (min_ticks_q == '0) ? DEN_W'(1) : DEN_W'(min_ticks_q);
		den_next = (ticks_e < floor_t) ? floor_t : ticks_e;
	end

	// Step of the total angle, wrapped once into half a turn, then clamped.
	always_comb begin
		diff_s = signed'(total_q - prev_total_q);
		if (diff_s > HALF_TURN) begin
			wrap_s = diff_s - FULL_TURN;
		end else if (diff_s < -HALF_TURN) begin
			wrap_s = diff_s + FULL_TURN;
		end else begin
			wrap_s = diff_s;
		end
		if (wrap_s > STEP_LIM) begin
			clamp_s = STEP_LIM;
		end else if (wrap_s < -STEP_LIM) begin
			clamp_s = -STEP_LIM;
		end else begin
			clamp_s = wrap_s;
		end
	end

	// Shared multiplier: step*tick_hz, then keep*old, then (256-keep)*new.
	always_comb begin
		keep_sat = (filter_keep_q > emv_pkg::KEEP_ONE) ? emv_pkg::KEEP_ONE : filter_keep_q;
		keep_inv = emv_pkg::KEEP_ONE - keep_sat;
		case (state_q)
			emv_pkg::ST_MUL_V: begin
				mul_a = MUL_A_W'(step_q);
				mul_b = signed'({1'b0, tick_hz_q});
			end
			emv_pkg::ST_MUL_OLD: begin
				mul_a = MUL_A_W'(filt_q);
				mul_b = signed'(MUL_B_W'(keep_sat));
			end
			emv_pkg::ST_MUL_NEW: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = signed'(MUL_B_W'(keep_inv));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Divide the magnitude; restore the sign and saturate afterward (truncates toward zero).
	always_comb begin
		mag_full = prod_q[PROD_W-1] ? unsigned'(-prod_q) : unsigned'(prod_q);
		div_num  = mag_full[MAG_W-1:0];
		q_e      = CMPQ_W'(div_quo);
		q_neg    = CMPQ_W'(0) - q_e;
		pos_lim  = CMPQ_W'(emv_pkg::VEL_POS_MAX);
		neg_lim  = pos_lim + CMPQ_W'(1);
		if (prod_q[PROD_W-1]) begin
			vel_next = (q_e > neg_lim) ? signed'(emv_pkg::VEL_NEG_MIN)
			                           : signed'(q_neg[VEL_W-1:0]);
		end else begin
			vel_next = (q_e > pos_lim) ? signed'(emv_pkg::VEL_POS_MAX)
			                           : signed'(q_e[VEL_W-1:0]);
		end
	end

	emv_div #(
		.NUM_W (MAG_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Filter sum; the arithmetic shift floors toward minus infinity.
	always_comb begin
		sum_s  = acc_q + SUM_W'(prod_q);
		sum_sh = sum_s >>> 8;
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			emv_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_next = emv_pkg::ST_UNWRAP;
				end
			end
			emv_pkg::ST_UNWRAP:   state_next = emv_pkg::ST_STEP;
			emv_pkg::ST_STEP:     state_next = emv_pkg::ST_MUL_V;
			emv_pkg::ST_MUL_V:    state_next = emv_pkg::ST_DIV_GO;
			emv_pkg::ST_DIV_GO:   state_next = emv_pkg::ST_DIV_WAIT;
			emv_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_next = emv_pkg::ST_SAT;
				end
			end
			emv_pkg::ST_SAT:      state_next = emv_pkg::ST_MUL_OLD;
			emv_pkg::ST_MUL_OLD:  state_next = emv_pkg::ST_MUL_NEW;
			emv_pkg::ST_MUL_NEW:  state_next = emv_pkg::ST_FILT;
			emv_pkg::ST_FILT:     state_next = emv_pkg::ST_OUT;
			emv_pkg::ST_OUT: begin
				if (out_free) begin
					state_next = emv_pkg::ST_IDLE;
				end
			end
			default:              state_next = emv_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		out_free  = !out_valid_q || m_tready;
		in_take   = (state_q == emv_pkg::ST_IDLE);
		div_start = (state_q == emv_pkg::ST_DIV_GO);
		out_load  = (state_q == emv_pkg::ST_OUT) && out_free;
	end

	assign s_tready = in_take;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Control and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= emv_pkg::ST_IDLE;
			prev_raw_q   <= '0;
			turn_count_q <= '0;
			prev_total_q <= '0;
			prev_stamp_q <= '0;
			filt_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == emv_pkg::ST_UNWRAP) begin
				prev_raw_q   <= raw_q;
				turn_count_q <= turn_next;
			end
			if (state_q == emv_pkg::ST_STEP) begin
				prev_total_q <= total_q;
				prev_stamp_q <= stamp_q;
			end
			if (state_q == emv_pkg::ST_FILT) begin
				filt_q <= sum_sh[VEL_W-1:0];
			end
			// Hold a result until taken; a new one loads only into a free slot.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (in_take && s_tvalid) begin
			raw_q   <= s_tdata[ANGLE_BITS-1:0];
			stamp_q <= s_tdata[ANGLE_BITS+STAMP_BITS-1:ANGLE_BITS];
		end
		case (state_q)
			emv_pkg::ST_UNWRAP: begin
				total_q <= total_next;
				den_q   <= den_next;
			end
			emv_pkg::ST_STEP: begin
				step_q <= STEP_W'(clamp_s);
			end
			emv_pkg::ST_MUL_V: begin
				prod_q <= mul_p;
			end
			emv_pkg::ST_SAT: begin
				vel_q <= vel_next;
			end
			emv_pkg::ST_MUL_OLD: begin
				prod_q <= mul_p;
			end
			emv_pkg::ST_MUL_NEW: begin
				acc_q  <= SUM_W'(prod_q);
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= {filt_q, total_q};
		end
	end

	// The divider finishes only while the sequencer waits for it.
	`ASSERT_IMPLIES(a_div_done_wait, clk, arst_n, div_done, state_q == emv_pkg::ST_DIV_WAIT)

	// The turn count moves only in the unwrap step.
	`ASSERT_NEXT(a_turn_hold, clk, arst_n, state_q != emv_pkg::ST_UNWRAP, $stable(turn_count_q))

	// The weighted filter sum always lands inside the velocity range after the shift.
	`ASSERT_IMPLIES(a_filt_range, clk, arst_n, state_q == emv_pkg::ST_FILT, (sum_s[SUM_W-1:VEL_W+7] == '0) || (sum_s[SUM_W-1:VEL_W+7] == '1))

endmodule

// ----- tb/sv/tb_encoder_multiturn_velocity.sv -----
// Testbench for the multi-turn encoder unwrapper and velocity estimator.
module tb_encoder_multiturn_velocity;
	import emv_pkg::*;

	localparam int ANGLE_BITS = 12;
	localparam int STAMP_BITS = 24;
	localparam int IN_W = ((ANGLE_BITS + STAMP_BITS + 7) / 8) * 8;
	localparam longint HALF_TURN = longint'(1) << (ANGLE_BITS - 1);
	localparam longint FULL_TURN = longint'(1) << ANGLE_BITS;
	// No handshake for this many cycles means the block is stuck; the limit
	// leaves room for long random stalls.
	localparam int WATCHDOG_LIMIT = 2000;
	// Quiet cycles after the last result before the verdict.
	localparam int TAIL_CYCLES = 64;
	localparam int PHASE_COUNT = 8;
	localparam int ITEMS_PER_PHASE = 230;

	// One result item: total angle and filtered velocity.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [VEL_W-1:0]   vel;
	} motion_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// raw_angle [11:0], tick_stamp [35:12], zero fill [39:36]
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// total_angle [43:0], velocity [79:44]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = CFG_JUMP_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Expected results, oldest first.
	motion_result_t motion_results[$];
	motion_result_t want;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	// Idling percentages of the current phase.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// Shadow of the configuration registers.
	logic [JUMP_W-1:0] reg_jump_limit = JUMP_RESET;
	logic [HZ_W-1:0]   reg_tick_hz = HZ_RESET;
	logic [MINT_W-1:0] reg_min_ticks = MINT_RESET;
	logic [KEEP_W-1:0] reg_filter_keep = KEEP_RESET;

	// Shadow of the unwrap and filter state.
	logic [ANGLE_BITS-1:0] est_prev_raw = '0;
	logic [TURN_W-1:0]     est_turns = '0;
	logic [TOTAL_W-1:0]    est_prev_total = '0;
	logic [STAMP_BITS-1:0] est_prev_stamp = '0;
	logic [VEL_W-1:0]      est_filt_vel = '0;

	// State of the synthetic shaft motion used for random items.
	logic [ANGLE_BITS-1:0] motion_raw = '0;
	logic [STAMP_BITS-1:0] motion_stamp = '1;
	int motion_speed = 37;
	int motion_dt = 900;

	encoder_multiturn_velocity #(
		.ANGLE_BITS(ANGLE_BITS),
		.STAMP_BITS(STAMP_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Unwrap one sample and advance the velocity filter; returns the result item.
	function automatic motion_result_t unwrap_estimate(input logic [ANGLE_BITS-1:0] raw,
			input logic [STAMP_BITS-1:0] stamp);
		motion_result_t res;
		logic [TOTAL_W-1:0] total;
		logic signed [TOTAL_W-1:0] diff;
		longint d;
		longint ticks;
		longint floor_t;
		longint step;
		longint vel;
		longint vel_hi;
		longint vel_lo;
		longint keep;
		longint old;
		longint mix;
		vel_hi = longint'($signed(VEL_POS_MAX));
		vel_lo = longint'($signed(VEL_NEG_MIN));

		// Count a turn against the sign of a raw step above the jump limit.
		d = longint'(raw) - longint'(est_prev_raw);
		if ((d < 0 ? -d : d) > longint'(reg_jump_limit))
			est_turns = (d > 0) ? est_turns - TURN_W'(1) : est_turns + TURN_W'(1);
		est_prev_raw = raw;
		total = {est_turns, raw};

		// Elapsed ticks of the down-counter, with wrap, then floored.
		if (stamp < est_prev_stamp)
			ticks = longint'(est_prev_stamp - stamp);
		else
			ticks = longint'({STAMP_BITS{1'b1}} - stamp) + longint'(est_prev_stamp);
		floor_t = (reg_min_ticks == '0) ? longint'(1) : longint'(reg_min_ticks);
		if (ticks < floor_t)
			ticks = floor_t;

		// Wrap the total step once to within half a turn, exactly half kept; then clamp.
		diff = total - est_prev_total;
		step = longint'(diff);
		if (step > HALF_TURN)
			step = step - FULL_TURN;
		else if (step < -HALF_TURN)
			step = step + FULL_TURN;
		if (step > 3 * FULL_TURN)
			step = 3 * FULL_TURN;
		if (step < -3 * FULL_TURN)
			step = -3 * FULL_TURN;

		// Integer division truncates toward zero, then saturate.
		vel = (step * longint'(reg_tick_hz)) / ticks;
		if (vel > vel_hi)
			vel = vel_hi;
		if (vel < vel_lo)
			vel = vel_lo;

		// First-order filter; the arithmetic shift floors toward minus infinity.
		keep = (reg_filter_keep > KEEP_ONE) ? longint'(256) : longint'(reg_filter_keep);
		old = longint'($signed(est_filt_vel));
		mix = (keep * old + (longint'(256) - keep) * vel) >>> 8;
		est_filt_vel = mix[VEL_W-1:0];

		est_prev_stamp = stamp;
		est_prev_total = total;
		res.total = total;
		res.vel = est_filt_vel;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Monitor: check results first, then track register writes and predict for
	// accepted items, all at the same edge in one process.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (motion_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, data %h", m_tdata));
				end else begin
					want = motion_results.pop_front();
					if (m_tdata[TOTAL_W-1:0] !== want.total)
						report_mismatch($sformatf("total_angle got %0d want %0d",
							$signed(m_tdata[TOTAL_W-1:0]), $signed(want.total)));
					if (m_tdata[TOTAL_W+VEL_W-1:TOTAL_W] !== want.vel)
						report_mismatch($sformatf("velocity got %0d want %0d",
							$signed(m_tdata[TOTAL_W+VEL_W-1:TOTAL_W]), $signed(want.vel)));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_JUMP_LIMIT:  reg_jump_limit = cfg_data[JUMP_W-1:0];
					CFG_TICK_HZ:     reg_tick_hz = cfg_data[HZ_W-1:0];
					CFG_MIN_TICKS:   reg_min_ticks = cfg_data[MINT_W-1:0];
					CFG_FILTER_KEEP: reg_filter_keep = cfg_data[KEEP_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				motion_results.push_back(unwrap_estimate(s_tdata[ANGLE_BITS-1:0],
					s_tdata[ANGLE_BITS+STAMP_BITS-1:ANGLE_BITS]));
		end
	end

	// Receiver: stall at random with the phase's percentage.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);

	// Watchdog: end the run when no handshake happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Send one sample; hold valid until it is taken, idling first at random.
	task automatic send_sample(input logic [ANGLE_BITS-1:0] raw,
			input logic [STAMP_BITS-1:0] stamp);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({stamp, raw});
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (motion_results.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; the caller makes sure the block is idle.
	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_registers(input logic [JUMP_W-1:0] jump,
			input logic [HZ_W-1:0] hz, input logic [MINT_W-1:0] min_t,
			input logic [KEEP_W-1:0] keep);
		drain_results();
		write_register(CFG_JUMP_LIMIT, CFG_DATA_W'(jump));
		write_register(CFG_TICK_HZ, CFG_DATA_W'(hz));
		write_register(CFG_MIN_TICKS, CFG_DATA_W'(min_t));
		write_register(CFG_FILTER_KEEP, CFG_DATA_W'(keep));
	endtask

	// Turn detection and half-turn wrapping at the reset settings.
	task automatic test_angle_unwrap();
		send_sample(12'd0, 24'hFFFFF0);    // stamp above the old one: counter wrap
		send_sample(12'd4095, 24'hFFFF00); // large positive step: one turn back
		send_sample(12'd0, 24'hFFFE00);    // large negative step: one turn forward
		send_sample(12'd2048, 24'hFFFD00); // exactly plus half a turn, kept
		send_sample(12'd0, 24'hFFFC00);    // exactly minus half a turn, kept
		send_sample(12'd2049, 24'hFFFB00); // just over half a turn, wrapped
		send_sample(12'd0, 24'hFFFA00);
	endtask

	// Elapsed tick corner cases: equal stamps, one tick, zero after wrap.
	task automatic test_tick_elapsed();
		send_sample(12'd10, 24'hFFFA00);   // equal stamp: full counter range
		send_sample(12'd20, 24'hFFF9FF);   // one tick, raised to the floor
		send_sample(12'd30, 24'h000000);
		send_sample(12'd40, 24'hFFFFFF);   // wraps to zero elapsed
		// Zero floor acts as one; full-scale rate with one tick stays below saturation.
		write_all_registers(JUMP_RESET, 24'hFFFFFF, 24'd0, 9'd0);
		send_sample(12'd40, 24'h000000);
		send_sample(12'd2088, 24'hFFFFFF);
		send_sample(12'd40, 24'hFFFFFE);
		// Zero tick rate gives zero velocity.
		write_all_registers(JUMP_RESET, 24'd0, MINT_RESET, KEEP_RESET);
		send_sample(12'd1000, 24'hFFF000);
		write_all_registers(JUMP_RESET, 24'hFFFFFF, 24'hFFFFFF, KEEP_RESET);
		send_sample(12'd3000, 24'hFF0000);
	endtask

	// Filter weight at 256 and beyond, jump limit at both ends.
	task automatic test_filter_and_jump();
		write_all_registers(12'd0, HZ_RESET, MINT_RESET, KEEP_ONE);
		send_sample(12'd3001, 24'hF00000); // step of one count still counts a turn
		send_sample(12'd100, 24'hEFF000);
		write_all_registers(12'd0, HZ_RESET, MINT_RESET, 9'd511);
		send_sample(12'd200, 24'hEFE000);  // keep above 256 holds the old value
		write_all_registers(12'd4095, HZ_RESET, MINT_RESET, 9'd128);
		send_sample(12'd4095, 24'hEFD000); // no turn can be counted
		send_sample(12'd0, 24'hEFC000);
	endtask

	// Mostly smooth shaft motion with random content, some noise items.
	task automatic send_motion_or_noise();
		logic [ANGLE_BITS-1:0] raw;
		logic [STAMP_BITS-1:0] stamp;
		if ($urandom_range(99) < 12) begin
			raw = ANGLE_BITS'($urandom);
			stamp = STAMP_BITS'($urandom);
		end else begin
			if ($urandom_range(99) < 5) begin
				motion_speed = int'($urandom_range(0, 4000)) - 2000;
				motion_dt = int'($urandom_range(1, 60000));
			end
			motion_raw = motion_raw + ANGLE_BITS'(motion_speed + int'($urandom_range(0, 6)) - 3);
			motion_stamp = motion_stamp - STAMP_BITS'(motion_dt + int'($urandom_range(0, 8)));
			raw = motion_raw;
			stamp = motion_stamp;
		end
		send_sample(raw, stamp);
	endtask

	// Random phases: new settings and a new idling pattern each phase.
	task automatic test_random_motion();
		int phase;
		int n;
		logic [JUMP_W-1:0] jump;
		logic [HZ_W-1:0] hz;
		logic [MINT_W-1:0] min_t;
		logic [KEEP_W-1:0] keep;
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					jump = JUMP_RESET; hz = HZ_RESET; min_t = MINT_RESET; keep = KEEP_RESET;
				end
				1: begin
					jump = '0; hz = 24'd1; min_t = '0; keep = '0;
				end
				2: begin
					jump = '1; hz = '1; min_t = '1; keep = '1;
				end
				default: begin
					jump = JUMP_W'($urandom_range(0, 4095));
					hz = ($urandom_range(9) == 0) ? '0 : HZ_W'($urandom_range(1, 24'hFFFFFF));
					case ($urandom_range(3))
						0: min_t = '0;
						1: min_t = MINT_W'($urandom_range(1, 64));
						2: min_t = MINT_W'($urandom_range(1, 100000));
						default: min_t = MINT_W'($urandom);
					endcase
					keep = ($urandom_range(3) == 0) ? KEEP_W'($urandom_range(257, 511))
						: KEEP_W'($urandom_range(0, 256));
				end
			endcase
			write_all_registers(jump, hz, min_t, keep);
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
				default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Hold off once mid-phase until the block has emptied.
				if (phase == 3 && n == ITEMS_PER_PHASE / 2)
					drain_results();
				send_motion_or_noise();
			end
		end
	endtask

	initial begin
		// Hold reset, then release it at a clock edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_angle_unwrap();
		test_tick_elapsed();
		test_filter_and_jump();
		test_random_motion();

		// Let the last results drain, then a quiet tail; the watchdog bounds both.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && motion_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/emv_pkg.sv
rtl/emv_div.sv
rtl/encoder_multiturn_velocity.sv
tb/sv/tb_encoder_multiturn_velocity.sv
